### sv/sdes_pkg.sv
// sdes_pkg: shared types, reset constants and the fixed s-des permutations
// used by the configuration registers, the round function and the top level
// no dependencies
package sdes_pkg;

	localparam int unsigned KeyW   = 10;
	localparam int unsigned BlockW = 8;
	localparam int unsigned HalfW  = 4;
	localparam int unsigned SubW   = 8;
	localparam int unsigned TableW = 32;

	// register indexes on the write port
	localparam logic REG_SBOX0 = 1'b0;
	localparam logic REG_SBOX1 = 1'b1;

	localparam logic [TableW-1:0] SBOX0_RESET = 32'hB7D8_1BB1;
	localparam logic [TableW-1:0] SBOX1_RESET = 32'hC613_D2E5;

	// command codes
	localparam logic CMD_ENCRYPT = 1'b0;
	localparam logic CMD_DECRYPT = 1'b1;

	typedef struct packed {
		logic [TableW-1:0] s0;
		logic [TableW-1:0] s1;
	} sbox_cfg_t;

	// string position 0 is the msb in every table below

	function automatic logic [KeyW-1:0] p10(input logic [KeyW-1:0] k);
		return {k[7], k[5], k[8], k[3], k[6], k[0], k[9], k[1], k[2], k[4]};
	endfunction

	function automatic logic [SubW-1:0] p8(input logic [KeyW-1:0] k);
		return {k[4], k[7], k[3], k[6], k[2], k[5], k[0], k[1]};
	endfunction

	function automatic logic [BlockW-1:0] ip(input logic [BlockW-1:0] b);
		return {b[6], b[2], b[5], b[7], b[4], b[0], b[3], b[1]};
	endfunction

	function automatic logic [BlockW-1:0] ip_inv(input logic [BlockW-1:0] b);
		return {b[4], b[7], b[5], b[3], b[1], b[6], b[0], b[2]};
	endfunction

	function automatic logic [SubW-1:0] ep(input logic [HalfW-1:0] r);
		return {r[0], r[3], r[2], r[1], r[2], r[1], r[0], r[3]};
	endfunction

	function automatic logic [HalfW-1:0] p4(input logic [HalfW-1:0] v);
		return {v[2], v[0], v[1], v[3]};
	endfunction

	function automatic logic [4:0] rotl1(input logic [4:0] v);
		return {v[3:0], v[4]};
	endfunction

	function automatic logic [4:0] rotl3(input logic [4:0] v);
		return {v[1:0], v[4:2]};
	endfunction

	// row is outer bits, column is inner bits; entries are 2 bits wide
	function automatic logic [1:0] sbox(input logic [TableW-1:0] tab,
			input logic [HalfW-1:0] nib);
		logic [3:0] idx;
		idx = {nib[3], nib[0], nib[2:1]};
		return tab[{idx, 1'b0} +: 2];
	endfunction

endpackage

### sv/sdes_cfg_regs.sv
// sdes_cfg_regs: the two s-box table registers behind the write port
// depends on sdes_pkg
module sdes_cfg_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic                      wr_index,
	input  logic [sdes_pkg::TableW-1:0] wr_data,
	output sdes_pkg::sbox_cfg_t       cfg
);
	import sdes_pkg::*;

	logic [TableW-1:0] sbox0_q;
	logic [TableW-1:0] sbox1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sbox0_q <= SBOX0_RESET;
			sbox1_q <= SBOX1_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SBOX0: sbox0_q <= wr_data;
				REG_SBOX1: sbox1_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg.s0 = sbox0_q;
	assign cfg.s1 = sbox1_q;

endmodule

### sv/sdes_fk.sv
// sdes_fk: one s-des round function, left xor p4(s-boxes(ep(right) xor key))
// depends on sdes_pkg
module sdes_fk (
	input  sdes_pkg::sbox_cfg_t      cfg,
	input  logic [sdes_pkg::HalfW-1:0] left,
	input  logic [sdes_pkg::HalfW-1:0] right,
	input  logic [sdes_pkg::SubW-1:0]  round_key,
	output logic [sdes_pkg::HalfW-1:0] new_left
);
	import sdes_pkg::*;

	logic [SubW-1:0] mixed;
	logic [1:0]      s0_out;
	logic [1:0]      s1_out;

	always_comb begin
		mixed    = ep(right) ^ round_key;
		s0_out   = sbox(cfg.s0, mixed[7:4]);
		s1_out   = sbox(cfg.s1, mixed[3:0]);
		new_left = left ^ p4({s0_out, s1_out});
	end

endmodule

### sv/sdes_block_cipher_top.sv
// sdes_block_cipher_top: three-stage s-des pipeline, one 8-bit block per beat
// an accepted beat is registered in stage 1, stage 2 and stage 3 in turn, then shows its result with done
// throughput: one beat per cycle, start may stay high; busy is always low
// results cannot be stalled, so the pipeline never holds; done lasts one cycle
// reset (arst_n low, async): valid bits clear, s-box tables return to their reset values
// depends on sdes_pkg, sdes_cfg_regs and sdes_fk
module sdes_block_cipher_top (
	input  logic                        clk,
	input  logic                        arst_n,
	// command channel
	input  logic                        start,
	output logic                        busy,
	input  logic                        command,
	input  logic [sdes_pkg::KeyW-1:0]   cipher_key,
	input  logic [sdes_pkg::BlockW-1:0] data_block,
	// result channel
	output logic                        done,
	output logic [sdes_pkg::BlockW-1:0] result_block,
	// s-box table write port
	input  logic                        wr_en,
	input  logic                        wr_index,
	input  logic [sdes_pkg::TableW-1:0] wr_data
);
	import sdes_pkg::*;

	sbox_cfg_t cfg;

	// table registers; write only while the pipeline is empty, the block itself does not enforce this
	sdes_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	// the pipeline never stalls, so a new beat is taken every cycle
	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// ---------------- stage 1: key schedule and initial permutation
	logic [KeyW-1:0]   k10;
	logic [4:0]        lo1, hi1, lo3, hi3;
	logic [SubW-1:0]   k1, k2;
	logic [BlockW-1:0] perm_in;

	always_comb begin
		k10     = p10(cipher_key);
		lo1     = rotl1(k10[9:5]);
		hi1     = rotl1(k10[4:0]);
		// k2 uses a further rotate by two, so three in all
		lo3     = rotl3(k10[9:5]);
		hi3     = rotl3(k10[4:0]);
		k1      = p8({lo1, hi1});
		k2      = p8({lo3, hi3});
		perm_in = ip(data_block);
	end

	logic             vld_s1;
	logic [SubW-1:0]  key_a_s1, key_b_s1;
	logic [HalfW-1:0] left_s1, right_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	// decryption runs the subkeys in the opposite order
	always_ff @(posedge clk) begin
		if (accept) begin
			key_a_s1 <= (command == CMD_DECRYPT) ? k2 : k1;
			key_b_s1 <= (command == CMD_DECRYPT) ? k1 : k2;
			left_s1  <= perm_in[7:4];
			right_s1 <= perm_in[3:0];
		end
	end

	// ---------------- stage 2: first round
	logic [HalfW-1:0] l1;

	sdes_fk u_round1 (
		.cfg       (cfg),
		.left      (left_s1),
		.right     (right_s1),
		.round_key (key_a_s1),
		.new_left  (l1)
	);

	logic             vld_s2;
	logic [SubW-1:0]  key_b_s2;
	logic [HalfW-1:0] l1_s2, r_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			key_b_s2 <= key_b_s1;
			l1_s2    <= l1;
			r_s2     <= right_s1;
		end
	end

	// ---------------- stage 3: swap, second round, inverse permutation
	logic [HalfW-1:0] l2;

	// after the swap the old right half is the left input
	sdes_fk u_round2 (
		.cfg       (cfg),
		.left      (r_s2),
		.right     (l1_s2),
		.round_key (key_b_s2),
		.new_left  (l2)
	);

	logic              vld_s3;
	logic [BlockW-1:0] result_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			result_s3 <= ip_inv({l2, l1_s2});
		end
	end

	// result beat, one cycle wide
	assign done         = vld_s3;
	assign result_block = result_s3;

endmodule

### sv/sdes_checker.sv
// sdes_checker: port-level checks of the s-des pipeline timing
// depends on sdes_pkg; bound to sdes_block_cipher_top below
module sdes_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        command,
	input logic [sdes_pkg::KeyW-1:0]   cipher_key,
	input logic [sdes_pkg::BlockW-1:0] data_block,
	input logic                        done,
	input logic [sdes_pkg::BlockW-1:0] result_block,
	input logic                        wr_en
);
	import sdes_pkg::*;

	// the pipeline takes a beat every cycle
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

	// every accepted beat yields exactly one result, raised on done
	a_accept_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##2 done)
		else $error("result missing after accepted beat");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> ##2 !done)
		else $error("result without accepted beat");

	// two identical beats back to back give identical results
	a_same_in_same_out: assert property (@(posedge clk) disable iff (!arst_n)
		(start && $past(start) && $past(arst_n) && !wr_en && !$past(wr_en)
			&& $stable(command) && $stable(cipher_key) && $stable(data_block))
		|-> ##3 $stable(result_block))
		else $error("identical beats gave different results");

endmodule

bind sdes_block_cipher_top sdes_checker u_sdes_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.command      (command),
	.cipher_key   (cipher_key),
	.data_block   (data_block),
	.done         (done),
	.result_block (result_block),
	.wr_en        (wr_en)
);

### sim/testbench.sv
// testbench for sdes_block_cipher_top: a table of directed beats, then random beats
// across several s-box tables, each result checked against a local model or a typed-in block
// depends on sdes_pkg and sdes_block_cipher_top
module testbench;
	import sdes_pkg::*;

	// spare cycles after the drain, to watch for any extra result
	localparam int unsigned DRAIN_CYCLES = 6;
	// cycles with no beat, result or table write before the run is called hung
	localparam int unsigned STALL_LIMIT  = 2000;
	localparam int unsigned PHASES       = 5;
	localparam int unsigned PHASE_BEATS  = 200;
	// the sender never idles during the last beats of the run
	localparam int unsigned CALM_BEATS   = 150;
	localparam int unsigned DIRECTED_ROWS = 24;

	// bit-position tables, 4 bits per entry, entry 0 leftmost
	// an entry names the source bit counted from the msb
	localparam logic [63:0] KEY_P10 = {24'd0, 4'd2, 4'd4, 4'd1, 4'd6, 4'd3,
		4'd9, 4'd0, 4'd8, 4'd7, 4'd5};
	localparam logic [63:0] KEY_P8  = {32'd0, 4'd5, 4'd2, 4'd6, 4'd3, 4'd7,
		4'd4, 4'd9, 4'd8};
	localparam logic [63:0] BLK_IP  = {32'd0, 4'd1, 4'd5, 4'd2, 4'd0, 4'd3,
		4'd7, 4'd4, 4'd6};
	localparam logic [63:0] BLK_IP_INV = {32'd0, 4'd3, 4'd0, 4'd2, 4'd4, 4'd6,
		4'd1, 4'd7, 4'd5};
	localparam logic [63:0] HALF_EP = {32'd0, 4'd3, 4'd0, 4'd1, 4'd2, 4'd1,
		4'd2, 4'd3, 4'd0};
	localparam logic [63:0] HALF_P4 = {48'd0, 4'd1, 4'd3, 4'd2, 4'd0};

	typedef enum logic {ROW_BEAT, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		logic               cmd;
		logic [KeyW-1:0]    key;
		logic [BlockW-1:0]  blk;
		logic               known;      // expected block typed into the row
		logic [BlockW-1:0]  known_blk;
		logic               reg_index;
		logic [TableW-1:0]  reg_value;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic command = CMD_ENCRYPT;
	logic [KeyW-1:0] cipher_key = '0;
	logic [BlockW-1:0] data_block = '0;
	logic done;
	logic [BlockW-1:0] result_block;
	logic wr_en = 1'b0;
	logic wr_index = REG_SBOX0;
	logic [TableW-1:0] wr_data = '0;

	// travels with start: the beat's expected block is fixed rather than predicted
	logic beat_known = 1'b0;
	logic [BlockW-1:0] beat_known_blk = '0;

	// local copy of the s-box tables, updated when a write is seen on the port
	logic [TableW-1:0] sbox0_copy = SBOX0_RESET;
	logic [TableW-1:0] sbox1_copy = SBOX1_RESET;

	logic [BlockW-1:0] expected_blocks[$];
	stim_row_t directed_rows [DIRECTED_ROWS];

	int unsigned beats_sent = 0;
	int unsigned blocks_checked = 0;
	int unsigned table_writes = 0;
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;

	sdes_block_cipher_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.cipher_key   (cipher_key),
		.data_block   (data_block),
		.done         (done),
		.result_block (result_block),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------------------------
	// s-des model
	// ---------------------------------------------------------------------------------

	// output bit j (from the msb) takes source bit tab[j] (from the msb)
	function automatic logic [31:0] reorder_bits(input logic [31:0] v, input int unsigned in_w,
			input logic [63:0] tab, input int unsigned out_w);
		logic [31:0] r;
		int unsigned src;
		r = '0;
		for (int unsigned j = 0; j < out_w; j++) begin
			src = in_w - 1 - tab[4*(out_w-1-j) +: 4];
			r = {r[30:0], v[src]};
		end
		return r;
	endfunction

	function automatic logic [4:0] rotate_half(input logic [4:0] v, input int unsigned n);
		logic [4:0] r;
		r = v;
		repeat (n) r = {r[3:0], r[4]};
		return r;
	endfunction

	// outer bits pick the row, inner bits the column; 2-bit entries packed from bit 0
	function automatic logic [1:0] sbox_lookup(input logic [TableW-1:0] tab,
			input logic [3:0] nib);
		int unsigned idx;
		idx = {nib[3], nib[0]} * 4 + nib[2:1];
		return tab[2*idx +: 2];
	endfunction

	// one feistel round: left xor p4(s-boxes(ep(right) xor subkey))
	function automatic logic [3:0] feistel_round(input logic [3:0] left, input logic [3:0] right,
			input logic [7:0] subkey, input logic [TableW-1:0] t0, input logic [TableW-1:0] t1);
		logic [7:0] x;
		logic [3:0] p;
		x = 8'(reorder_bits(32'(right), 4, HALF_EP, 8)) ^ subkey;
		p = 4'(reorder_bits(32'({sbox_lookup(t0, x[7:4]), sbox_lookup(t1, x[3:0])}),
			4, HALF_P4, 4));
		return left ^ p;
	endfunction

	function automatic logic [BlockW-1:0] cipher_block(input logic cmd,
			input logic [KeyW-1:0] key, input logic [BlockW-1:0] blk,
			input logic [TableW-1:0] t0, input logic [TableW-1:0] t1);
		logic [9:0] k10;
		logic [4:0] lo;
		logic [4:0] hi;
		logic [7:0] k1;
		logic [7:0] k2;
		logic [7:0] t;
		logic [3:0] l1;
		logic [3:0] l2;
		k10 = 10'(reorder_bits(32'(key), 10, KEY_P10, 10));
		lo = rotate_half(k10[9:5], 1);
		hi = rotate_half(k10[4:0], 1);
		k1 = 8'(reorder_bits(32'({lo, hi}), 10, KEY_P8, 8));
		lo = rotate_half(lo, 2);
		hi = rotate_half(hi, 2);
		k2 = 8'(reorder_bits(32'({lo, hi}), 10, KEY_P8, 8));
		t = 8'(reorder_bits(32'(blk), 8, BLK_IP, 8));
		// decryption runs the subkeys in the opposite order
		l1 = feistel_round(t[7:4], t[3:0], (cmd == CMD_DECRYPT) ? k2 : k1, t0, t1);
		l2 = feistel_round(t[3:0], l1, (cmd == CMD_DECRYPT) ? k1 : k2, t0, t1);
		return 8'(reorder_bits(32'({l2, l1}), 8, BLK_IP_INV, 8));
	endfunction

	// ---------------------------------------------------------------------------------
	// directed table rows
	// ---------------------------------------------------------------------------------

	function automatic stim_row_t beat_row(input logic cmd, input logic [KeyW-1:0] key,
			input logic [BlockW-1:0] blk);
		stim_row_t r;
		r = '{ROW_BEAT, cmd, key, blk, 1'b0, '0, REG_SBOX0, '0};
		return r;
	endfunction

	function automatic stim_row_t known_row(input logic cmd, input logic [KeyW-1:0] key,
			input logic [BlockW-1:0] blk, input logic [BlockW-1:0] res);
		stim_row_t r;
		r = '{ROW_BEAT, cmd, key, blk, 1'b1, res, REG_SBOX0, '0};
		return r;
	endfunction

	function automatic stim_row_t write_row(input logic idx, input logic [TableW-1:0] val);
		stim_row_t r;
		r = '{ROW_WRITE, CMD_ENCRYPT, '0, '0, 1'b0, '0, idx, val};
		return r;
	endfunction

	// ---------------------------------------------------------------------------------
	// sender side: everything driven with nonblocking assignments at the rising edge
	// ---------------------------------------------------------------------------------

	// returns at the edge that accepted the beat; start is left high for back-to-back beats
	task automatic send_beat(input logic cmd, input logic [KeyW-1:0] key,
			input logic [BlockW-1:0] blk, input logic known, input logic [BlockW-1:0] known_blk);
		start <= 1'b1;
		command <= cmd;
		cipher_key <= key;
		data_block <= blk;
		beat_known <= known;
		beat_known_blk <= known_blk;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic pause_sender(input int unsigned cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// hold off until every beat in flight has come back
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (expected_blocks.size() != 0) @(posedge clk);
	endtask

	// tables change only with the pipeline empty; every beat gives a result, so an
	// empty queue means nothing is in flight
	task automatic write_table(input logic idx, input logic [TableW-1:0] val);
		wait_drained();
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// ---------------------------------------------------------------------------------
	// monitor: samples at the edge, before that edge's updates land
	// ---------------------------------------------------------------------------------
	always @(posedge clk) begin
		logic [BlockW-1:0] want;
		logic active;
		if (arst_n) begin
			active = 1'b0;
			if (start && !busy) begin
				want = beat_known ? beat_known_blk
					: cipher_block(command, cipher_key, data_block, sbox0_copy, sbox1_copy);
				expected_blocks.push_back(want);
				beats_sent++;
				active = 1'b1;
			end
			if (done) begin
				active = 1'b1;
				if (expected_blocks.size() == 0) begin
					$error("result_block: no beat waiting, expected none, actual %02h",
						result_block);
					mismatches++;
				end else begin
					want = expected_blocks.pop_front();
					blocks_checked++;
					if (result_block !== want) begin
						$error("result_block: expected %02h, actual %02h", want, result_block);
						mismatches++;
					end
				end
			end
			if (wr_en) begin
				active = 1'b1;
				table_writes++;
				if (wr_index == REG_SBOX0)
					sbox0_copy = wr_data;
				else
					sbox1_copy = wr_data;
			end
			// watchdog
			if (active)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("hung for %0d cycles with %0d beats in flight", quiet_cycles,
					expected_blocks.size());
				$display("[sdes_block_cipher_top] ERROR");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------------------------
	initial begin
		int unsigned run_beats;
		int unsigned beat_no;
		logic idling_on;

		directed_rows = '{
			// reset tables: key and block extremes, both commands
			beat_row(CMD_ENCRYPT, 10'h000, 8'h00),
			beat_row(CMD_ENCRYPT, 10'h3FF, 8'hFF),
			beat_row(CMD_DECRYPT, 10'h000, 8'hFF),
			beat_row(CMD_DECRYPT, 10'h3FF, 8'h00),
			beat_row(CMD_ENCRYPT, 10'h2AA, 8'h55),
			beat_row(CMD_DECRYPT, 10'h155, 8'hAA),
			beat_row(CMD_ENCRYPT, 10'h201, 8'h80),
			beat_row(CMD_DECRYPT, 10'h100, 8'h01),
			// textbook s1 table, then the textbook vector both ways
			write_row(REG_SBOX1, 32'hC613_D2E4),
			known_row(CMD_ENCRYPT, 10'b1010000010, 8'b10010111, 8'b00111000),
			known_row(CMD_DECRYPT, 10'b1010000010, 8'b00111000, 8'b10010111),
			beat_row(CMD_ENCRYPT, 10'h3FF, 8'h00),
			// all-zero tables: the rounds only swap halves
			write_row(REG_SBOX0, 32'h0000_0000),
			write_row(REG_SBOX1, 32'h0000_0000),
			beat_row(CMD_ENCRYPT, 10'h155, 8'hAA),
			beat_row(CMD_DECRYPT, 10'h2AA, 8'h55),
			// all-ones tables
			write_row(REG_SBOX0, 32'hFFFF_FFFF),
			write_row(REG_SBOX1, 32'hFFFF_FFFF),
			beat_row(CMD_ENCRYPT, 10'h000, 8'hFF),
			beat_row(CMD_DECRYPT, 10'h3FF, 8'h00),
			// back to the reset tables
			write_row(REG_SBOX0, SBOX0_RESET),
			write_row(REG_SBOX1, SBOX1_RESET),
			beat_row(CMD_ENCRYPT, 10'h0F0, 8'h0F),
			beat_row(CMD_DECRYPT, 10'h30F, 8'hF0)
		};

		// reset once, released on an edge
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, back to back
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE)
				write_table(directed_rows[i].reg_index, directed_rows[i].reg_value);
			else
				send_beat(directed_rows[i].cmd, directed_rows[i].key, directed_rows[i].blk,
					directed_rows[i].known, directed_rows[i].known_blk);
		end

		// random part: each phase runs on its own table setting
		// phase 0 keeps the reset tables restored above
		run_beats = PHASES * PHASE_BEATS;
		idling_on = 1'b0;
		for (int unsigned phase = 0; phase < PHASES; phase++) begin
			case (phase)
				1, 4: begin
					write_table(REG_SBOX0, $urandom);
					write_table(REG_SBOX1, $urandom);
				end
				2: begin
					write_table(REG_SBOX0, 32'h0000_0000);
					write_table(REG_SBOX1, $urandom);
				end
				3: begin
					write_table(REG_SBOX0, $urandom);
					write_table(REG_SBOX1, 32'hFFFF_FFFF);
				end
				default: ;
			endcase
			for (int unsigned n = 0; n < PHASE_BEATS; n++) begin
				beat_no = phase * PHASE_BEATS + n;
				// idling switches on and off in stretches of 40 beats
				if (n % 40 == 0)
					idling_on = ($urandom_range(0, 2) != 0);
				if (phase == 2 && n == PHASE_BEATS / 2)
					wait_drained();     // let the pipeline run empty once mid-phase
				else if (idling_on && beat_no < run_beats - CALM_BEATS
						&& $urandom_range(0, 3) == 0)
					pause_sender($urandom_range(1, 6));
				send_beat(1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)),
					8'($urandom_range(0, 255)), 1'b0, '0);
			end
		end

		// let the last beats come back, then watch for anything extra
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d beats sent, %0d result blocks checked, %0d s-box table writes",
			beats_sent, blocks_checked, table_writes);
		$display("covered reset, textbook, all-zero, all-ones and random s-box tables");
		if (mismatches == 0) begin
			$display("[sdes_block_cipher_top] OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("[sdes_block_cipher_top] ERROR");
		end
		$finish;
	end

endmodule
